>>> rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg - rational arithmetic unit shared definitions
// Operand and result widths, beat types, opcodes and sequencer states.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPW   = 16;          // operand width
    localparam int PRODW = 2 * OPW;     // product / magnitude width
    localparam int NUMW  = 33;          // result numerator width
    localparam int DENW  = 31;          // result denominator width
    localparam int KW    = 5;           // common power-of-two count
    localparam int CNTW  = 5;           // divider bit counter

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } t_state;

    typedef struct packed {
        t_opcode                opcode;
        logic signed [OPW-1:0]  a_num;
        logic signed [OPW-1:0]  a_den;
        logic signed [OPW-1:0]  b_num;
        logic signed [OPW-1:0]  b_den;
    } t_in;

    typedef struct packed {
        logic signed [NUMW-1:0] res_num;
        logic [DENW-1:0]        res_den;
        logic                   div_zero;
    } t_out;

    // magnitude of a two's complement operand; the most negative value
    // maps to the top bit alone
    function automatic logic [OPW-1:0] f_mag(input logic [OPW-1:0] v);
        return v[OPW-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

>>> rtl/core/rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core - signed fraction add/sub/mul/div with reduce
// Cross-multiplies two fractions, then reduces by the gcd of the raw terms.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  (i_in_valid / o_in_stall / i_in_data): one beat carries an
//   opcode and two fractions. Output channel (o_out_valid / i_out_stall /
//   o_out_data): one beat per input beat, numerator signed, denominator
//   positive, div_zero set with zero fields when the raw denominator is zero.
//   One item is in work at a time; o_in_stall is high while it runs.
//   Steps per item, from the accepting edge to the output register:
//     products on the single 16x16 multiplier (S_MUL0..S_MUL2), a sign/magnitude
//     sum, binary gcd (one shift or subtract-and-shift per cycle), restoring
//     division of numerator then denominator by the odd gcd part, output load.
//   Zero numerator or zero denominator skip the gcd and divisions. The
//   sequencer returns to idle before the next beat is taken. The gcd and both
//   divisions share one 33-bit subtractor.
//   A finished result sits in the output register; the next item is taken
//   while it waits. If the receiver stalls and the next result is done, the
//   sequencer holds that result until the register frees.
//   Reset (synchronous, active low) returns the sequencer to idle and drops
//   o_out_valid.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rau_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rau_pkg::t_out o_out_data
);
    import rau_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_opcode           r_opc;
    logic [OPW-1:0]    r_an;
    logic [OPW-1:0]    r_ad;
    logic [OPW-1:0]    r_bn;
    logic [OPW-1:0]    r_bd;
    logic              r_an_s;
    logic              r_ad_s;
    logic              r_bn_s;
    logic              r_bd_s;
    logic [PRODW-1:0]  r_t0;
    logic [PRODW-1:0]  r_t1;
    logic              r_t0_s;
    logic              r_t1_s;
    logic [PRODW-1:0]  r_num;
    logic [PRODW-1:0]  r_den;
    logic              r_num_s;
    logic              r_den_s;
    logic              r_err;
    logic [PRODW-1:0]  r_p;
    logic [PRODW-1:0]  r_q;
    logic [KW-1:0]     r_k;
    logic [PRODW-1:0]  r_quo;
    logic [PRODW-1:0]  r_rem;
    logic [CNTW-1:0]   r_cnt;
    logic              r_out_vld;
    t_out              r_out;
    t_out              n_out;

    logic              in_acc;
    logic              out_free;
    logic              out_load;

    logic [OPW-1:0]    mul_a;
    logic [OPW-1:0]    mul_b;
    logic              mul_s;
    logic [PRODW-1:0]  mul_p;
    logic              mul_neg;

    logic [PRODW:0]    sum_add;
    logic [PRODW:0]    sum_dif;
    logic [PRODW-1:0]  sum_mag;
    logic              sum_s;

    logic [PRODW:0]    alu_a;
    logic [PRODW:0]    alu_b;
    logic [PRODW:0]    alu_y;
    logic [PRODW-1:0]  qmp;
    logic [PRODW:0]    rem_sh;
    logic              div_bit;
    logic [PRODW-1:0]  quo_nx;
    logic [PRODW-1:0]  rem_nx;
    logic              cnt_last;

    logic              res_neg;
    logic [NUMW-1:0]   num_ext;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_vld || !i_out_stall;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_MUL0;
            end
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM: begin
                if ((r_den == '0) || (sum_mag == '0)) n_state = S_DONE;
                else n_state = S_GCD;
            end
            S_GCD: begin
                if (r_p == r_q) n_state = S_DIVN;
            end
            S_DIVN: begin
                if (cnt_last) n_state = S_DIVD;
            end
            S_DIVD: begin
                if (cnt_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_DONE: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- shared multiplier ----------------
    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        mul_s = 1'b0;
        case (r_state)
            S_MUL0: begin
                mul_a = r_an;
                if (r_opc == OP_MUL) begin
                    mul_b = r_bn;
                    mul_s = r_an_s ^ r_bn_s;
                end else begin
                    mul_b = r_bd;
                    mul_s = r_an_s ^ r_bd_s;
                end
            end
            S_MUL1: begin
                // second cross term; subtract flips the sign of b
                mul_a = r_bn;
                mul_b = r_ad;
                mul_s = r_bn_s ^ (r_opc == OP_SUB) ^ r_ad_s;
            end
            S_MUL2: begin
                mul_a = r_ad;
                if (r_opc == OP_DIV) begin
                    mul_b = r_bn;
                    mul_s = r_ad_s ^ r_bn_s;
                end else begin
                    mul_b = r_bd;
                    mul_s = r_ad_s ^ r_bd_s;
                end
            end
            default: ;
        endcase
    end

    assign mul_p   = PRODW'(mul_a) * PRODW'(mul_b);
    assign mul_neg = mul_s && (mul_p != '0);

    // ---------------- sign/magnitude numerator ----------------
    assign sum_add = {1'b0, r_t0} + {1'b0, r_t1};
    assign sum_dif = {1'b0, r_t0} - {1'b0, r_t1};

    always_comb begin
        sum_mag = r_t0;
        sum_s   = r_t0_s;
        if ((r_opc == OP_ADD) || (r_opc == OP_SUB)) begin
            if (r_t0_s == r_t1_s) begin
                sum_mag = sum_add[PRODW-1:0];
                sum_s   = r_t0_s;
            end else if (!sum_dif[PRODW]) begin
                sum_mag = sum_dif[PRODW-1:0];
                sum_s   = r_t0_s;
            end else begin
                sum_mag = r_t1 - r_t0;
                sum_s   = r_t1_s;
            end
        end
        if (sum_mag == '0) sum_s = 1'b0;
    end

    // ---------------- shared subtractor ----------------
    assign rem_sh = {r_rem, r_quo[PRODW-1]};

    always_comb begin
        alu_a = {1'b0, r_p};
        alu_b = {1'b0, r_q};
        case (r_state)
            S_DIVN, S_DIVD: begin
                alu_a = rem_sh;
                alu_b = {1'b0, r_p};
            end
            default: ;
        endcase
    end

    assign alu_y    = alu_a - alu_b;
    assign qmp      = r_q - r_p;
    assign div_bit  = !alu_y[PRODW];
    assign quo_nx   = {r_quo[PRODW-2:0], div_bit};
    assign rem_nx   = div_bit ? alu_y[PRODW-1:0] : rem_sh[PRODW-1:0];
    assign cnt_last = (r_cnt == CNTW'(PRODW - 1));

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_opc  <= i_in_data.opcode;
                    r_an   <= f_mag(i_in_data.a_num);
                    r_ad   <= f_mag(i_in_data.a_den);
                    r_bn   <= f_mag(i_in_data.b_num);
                    r_bd   <= f_mag(i_in_data.b_den);
                    r_an_s <= i_in_data.a_num[OPW-1];
                    r_ad_s <= i_in_data.a_den[OPW-1];
                    r_bn_s <= i_in_data.b_num[OPW-1];
                    r_bd_s <= i_in_data.b_den[OPW-1];
                end
            end
            S_MUL0: begin
                r_t0   <= mul_p;
                r_t0_s <= mul_neg;
            end
            S_MUL1: begin
                r_t1   <= mul_p;
                r_t1_s <= mul_neg;
            end
            S_MUL2: begin
                r_den   <= mul_p;
                r_den_s <= mul_neg;
            end
            S_SUM: begin
                r_err <= (r_den == '0);
                if (r_den == '0) begin
                    r_num   <= '0;
                    r_num_s <= 1'b0;
                    r_den_s <= 1'b0;
                end else if (sum_mag == '0) begin
                    r_num   <= '0;
                    r_den   <= PRODW'(1);
                    r_num_s <= 1'b0;
                    r_den_s <= 1'b0;
                end else begin
                    r_num   <= sum_mag;
                    r_num_s <= sum_s;
                    r_p     <= sum_mag;
                    r_q     <= r_den;
                    r_k     <= '0;
                end
            end
            S_GCD: begin
                // binary gcd: r_p ends as the odd part, r_k the shared twos
                if (r_p == r_q) begin
                    r_quo <= r_num >> r_k;
                    r_rem <= '0;
                    r_cnt <= '0;
                end else if (!r_p[0] && !r_q[0]) begin
                    r_p <= r_p >> 1;
                    r_q <= r_q >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_p[0]) begin
                    r_p <= r_p >> 1;
                end else if (!r_q[0]) begin
                    r_q <= r_q >> 1;
                end else if (!alu_y[PRODW]) begin
                    r_p <= {1'b0, alu_y[PRODW-1:1]};
                end else begin
                    r_q <= {1'b0, qmp[PRODW-1:1]};
                end
            end
            S_DIVN: begin
                if (cnt_last) begin
                    r_num <= quo_nx;
                    r_quo <= r_den >> r_k;
                    r_rem <= '0;
                    r_cnt <= '0;
                end else begin
                    r_quo <= quo_nx;
                    r_rem <= rem_nx;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_DIVD: begin
                if (cnt_last) begin
                    r_den <= quo_nx;
                    r_cnt <= '0;
                end else begin
                    r_quo <= quo_nx;
                    r_rem <= rem_nx;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    assign res_neg = r_num_s ^ r_den_s;
    assign num_ext = {1'b0, r_num};

    always_comb begin
        n_out.res_num  = res_neg ? -num_ext : num_ext;
        n_out.res_den  = r_den[DENW-1:0];
        n_out.div_zero = r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker - port-level checks for the rational arithmetic unit
// Watches the output beat contents and the busy behavior of the input side.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input rau_pkg::t_out o_out_data
);
    import rau_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed under stall");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.div_zero |->
            (o_out_data.res_num == '0) && (o_out_data.res_den == '0))
        else $error("error beat with nonzero fields");

    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.div_zero |-> o_out_data.res_den != '0)
        else $error("zero denominator without error flag");

    a_zero_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.div_zero && (o_out_data.res_num == '0) |->
            o_out_data.res_den == DENW'(1))
        else $error("zero result not reduced to 0/1");

    // one item at a time: the block is busy right after taking a beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while an item is in work");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);
